>>> sv/tcf_pkg.sv
// tcf_pkg: shared types, constants and the control store of the tilt filter
// used by tcf_datapath and tilt_complementary_filter; no dependencies
`default_nettype none

package tcf_pkg;

  // fixed point format of the fused angle
  localparam int FRAC_BITS = 16;
  localparam int FUSED_W   = 10 + FRAC_BITS;

  // working width of the fused angle and its error term (signed)
  localparam int XW   = FRAC_BITS + 19;
  // shared multiplier operands and product
  localparam int MA_W = XW;
  localparam int MB_W = 17;
  localparam int PW   = MA_W + MB_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GYRO_OFFSET  = 3'd0,
    CFG_GYRO_GAIN    = 3'd1,
    CFG_RATE_COEFF   = 3'd2,
    CFG_FUSION_COEFF = 3'd3,
    CFG_FUSED_MIN    = 3'd4,
    CFG_FUSED_MAX    = 3'd5
  } cfg_idx_e;

  // reset values of the registers and the state
  localparam logic [7:0]  RST_GYRO_OFFSET  = 8'd26;
  localparam logic [15:0] RST_GYRO_GAIN    = 16'd32408;
  localparam logic [15:0] RST_RATE_COEFF   = 16'd328;
  localparam logic [15:0] RST_FUSION_COEFF = 16'd328;
  localparam logic [9:0]  RST_FUSED_MIN    = 10'd100;
  localparam logic [9:0]  RST_FUSED_MAX    = 10'd900;
  localparam logic [9:0]  RST_FUSED_INT    = 10'd100;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_GAIN = 2'd0,
    MUL_RC   = 2'd1,
    MUL_FC   = 2'd2
  } mul_sel_e;

  // program steps
  typedef enum logic [2:0] {
    ST_IN    = 3'd0,
    ST_MULG  = 3'd1,
    ST_RATE  = 3'd2,
    ST_MULRC = 3'd3,
    ST_SUB   = 3'd4,
    ST_MULFC = 3'd5,
    ST_FUSE  = 3'd6
  } step_e;

  // datapath control, one set per step
  typedef struct packed {
    mul_sel_e mul_sel;
    logic     load_in;
    logic     mul_en;
    logic     rate_en;
    logic     sub_en;
    logic     fuse_en;
  } ctrl_t;

  // one control word of the program
  typedef struct packed {
    ctrl_t ctrl;
    logic  wait_in;
    logic  wait_out;
    step_e next;
  } ucode_t;

  // results handed from datapath to the output register
  typedef struct packed {
    logic [9:0]         rate_out;
    logic [9:0]         fused_angle_out;
    logic signed [11:0] unfused_angle;
  } res_t;

  // control store
  function automatic ucode_t tcf_ucode(step_e s);
    ucode_t w;
    w.ctrl.mul_sel = MUL_GAIN;
    w.ctrl.load_in = 1'b0;
    w.ctrl.mul_en  = 1'b0;
    w.ctrl.rate_en = 1'b0;
    w.ctrl.sub_en  = 1'b0;
    w.ctrl.fuse_en = 1'b0;
    w.wait_in      = 1'b0;
    w.wait_out     = 1'b0;
    w.next         = ST_IN;
    case (s)
      ST_IN: begin
        w.ctrl.load_in = 1'b1;
        w.wait_in      = 1'b1;
        w.next         = ST_MULG;
      end
      ST_MULG: begin
        w.ctrl.mul_sel = MUL_GAIN;
        w.ctrl.mul_en  = 1'b1;
        w.next         = ST_RATE;
      end
      ST_RATE: begin
        w.ctrl.rate_en = 1'b1;
        w.next         = ST_MULRC;
      end
      ST_MULRC: begin
        w.ctrl.mul_sel = MUL_RC;
        w.ctrl.mul_en  = 1'b1;
        w.next         = ST_SUB;
      end
      ST_SUB: begin
        w.ctrl.sub_en = 1'b1;
        w.next        = ST_MULFC;
      end
      ST_MULFC: begin
        w.ctrl.mul_sel = MUL_FC;
        w.ctrl.mul_en  = 1'b1;
        w.next         = ST_FUSE;
      end
      ST_FUSE: begin
        w.ctrl.fuse_en = 1'b1;
        w.wait_out     = 1'b1;
        w.next         = ST_IN;
      end
      default: begin
        w.next = ST_IN;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> sv/tcf_datapath.sv
// tcf_datapath: registers, shared multiplier and fused angle state of the tilt filter
// depends on tcf_pkg; driven step by step by the sequencer in the top level
`default_nettype none

module tcf_datapath
  import tcf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_t              ctrl_i,
  input  wire logic signed [15:0] accel_sample_i,
  input  wire logic signed [15:0] gyro_sample_i,
  input  wire logic [7:0]         gyro_offset_i,
  input  wire logic [15:0]        gyro_gain_i,
  input  wire logic [15:0]        rate_coeff_i,
  input  wire logic [15:0]        fusion_coeff_i,
  input  wire logic [9:0]         fused_min_i,
  input  wire logic [9:0]         fused_max_i,
  output res_t                    res_o
);

  logic signed [11:0]   ang_q, ang_d;
  logic signed [14:0]   gv_q, gv_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [15:0]   rate_q, rate_d;
  logic signed [XW-1:0] x_q, x_d;
  logic signed [XW-1:0] err_q, err_d;
  logic [FUSED_W-1:0]   fused_q, fused_d;

  // accelerometer angle and offset gyro value
  logic signed [15:0] accel_sh, gyro_sh;
  logic signed [14:0] ang_sum;
  logic signed [16:0] gyro_ext, gv_wide;

  always_comb begin
    accel_sh = accel_sample_i >>> 2;
    gyro_sh  = gyro_sample_i >>> 2;
    ang_sum  = 15'(accel_sh) + 15'sd4000;
    ang_d    = 12'(ang_sum >>> 3);
    gyro_ext = 17'(gyro_sh);
    gv_wide  = -gyro_ext - $signed({9'd0, gyro_offset_i});
    gv_d     = 15'(gv_wide);
  end

  // shared multiplier
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_GAIN: begin
        mul_a = MA_W'(gv_q);
        mul_b = $signed({1'b0, gyro_gain_i});
      end
      MUL_RC: begin
        mul_a = MA_W'(rate_q);
        mul_b = $signed({1'b0, rate_coeff_i});
      end
      MUL_FC: begin
        mul_a = err_q;
        mul_b = $signed({1'b0, fusion_coeff_i});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // rate: product truncated toward zero by 14 bits, saturated to 16 bits
  logic signed [PW-15:0] rate_t;

  always_comb begin
    rate_t = (PW-14)'(prod_q >>> 14);
    if (prod_q[PW-1] && (|prod_q[13:0])) begin
      rate_t = rate_t + (PW-14)'(1);
    end
    if (rate_t > 32767) begin
      rate_d = 16'sh7fff;
    end else if (rate_t < -32768) begin
      rate_d = -16'sh8000;
    end else begin
      rate_d = 16'(rate_t);
    end
  end

  // rate integration: rate * rate_coeff rescaled to the state format, then error
  logic signed [PW+FRAC_BITS-1:0] term_sh, term_t;
  logic signed [XW-1:0]           term, fused_ext, ang_fx, x_sub;

  always_comb begin
    term_sh = $signed({prod_q, {FRAC_BITS{1'b0}}});
    term_t  = term_sh >>> 16;
    if (term_sh[PW+FRAC_BITS-1] && (|term_sh[15:0])) begin
      term_t = term_t + (PW+FRAC_BITS)'(1);
    end
    term      = XW'(term_t);
    fused_ext = $signed({{(XW-FUSED_W){1'b0}}, fused_q});
    x_sub     = fused_ext - term;
    ang_fx    = XW'(ang_q) <<< FRAC_BITS;
    err_d     = ang_fx - x_sub;
  end

  // fusion step, clamp and results
  logic signed [PW-17:0] fuse_t;
  logic signed [XW-1:0]  x_fuse, lo, hi, x_clamp;
  logic [9:0]            ip;
  logic signed [16:0]    rate_ext, ro_sum, ro_half;

  always_comb begin
    fuse_t = (PW-16)'(prod_q >>> 16);
    if (prod_q[PW-1] && (|prod_q[15:0])) begin
      fuse_t = fuse_t + (PW-16)'(1);
    end
    x_fuse = x_q + XW'(fuse_t);
    lo = $signed({{(XW-FUSED_W){1'b0}}, fused_min_i, {FRAC_BITS{1'b0}}});
    hi = $signed({{(XW-FUSED_W){1'b0}}, fused_max_i, {FRAC_BITS{1'b0}}});
    if (x_fuse < lo) begin
      x_clamp = lo;
    end else if (x_fuse > hi) begin
      x_clamp = hi;
    end else begin
      x_clamp = x_fuse;
    end
    fused_d = x_clamp[FUSED_W-1:0];
    ip      = x_clamp[FUSED_W-1:FRAC_BITS];

    res_o.unfused_angle = ang_q;
    if (ip > 10'd999) begin
      res_o.fused_angle_out = 10'd0;
    end else begin
      res_o.fused_angle_out = 10'd999 - ip;
    end

    rate_ext = 17'(rate_q);
    ro_sum   = rate_ext + 17'sd1000;
    ro_half  = ro_sum >>> 1;
    if (ro_half < 0) begin
      res_o.rate_out = 10'd0;
    end else if (ro_half > 17'sd999) begin
      res_o.rate_out = 10'd999;
    end else begin
      res_o.rate_out = ro_half[9:0];
    end
  end

  // x holds the state after rate integration
  assign x_d = x_sub;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      ang_q <= ang_d;
      gv_q  <= gv_d;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.rate_en) begin
      rate_q <= rate_d;
    end
    if (ctrl_i.sub_en) begin
      x_q   <= x_d;
      err_q <= err_d;
    end
  end

  // fused angle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fused_q <= {RST_FUSED_INT, {FRAC_BITS{1'b0}}};
    end else if (ctrl_i.fuse_en) begin
      fused_q <= fused_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/tilt_complementary_filter.sv
// tilt_complementary_filter: top level with stream ports, registers and step sequencer
// depends on tcf_pkg and tcf_datapath
`default_nettype none

// Fuses one accelerometer Z and one gyro Y sample per transaction into a tilt
// angle kept in unsigned fixed point with FRAC_BITS fraction bits, and returns
// the unfused angle, the fused angle and the scaled rate as one result. After
// acceptance, an item runs through the six steps after the input step of the
// seven-step control program, which runs one shared multiplier over three
// dependent products (gyro gain, rate coefficient, fusion coefficient); the last
// step loads the result into the output register, and a new item is accepted no
// earlier than the cycle after that, so items do not overlap; the last step waits
// while an earlier result is still unread. The user must write registers through
// the plain write port only while no item is in flight; the block does not
// enforce this.
module tilt_complementary_filter
  import tcf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [31:0]           s_axis_tdata,  // accel_sample[15:0], gyro_sample[31:16]
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // unfused_angle[11:0],
                                                    // fused_angle_out[21:12], rate_out[31:22]
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [7:0]  gyro_offset_q;
  logic [15:0] gyro_gain_q, rate_coeff_q, fusion_coeff_q;
  logic [9:0]  fused_min_q, fused_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_offset_q  <= RST_GYRO_OFFSET;
      gyro_gain_q    <= RST_GYRO_GAIN;
      rate_coeff_q   <= RST_RATE_COEFF;
      fusion_coeff_q <= RST_FUSION_COEFF;
      fused_min_q    <= RST_FUSED_MIN;
      fused_max_q    <= RST_FUSED_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GYRO_OFFSET:  gyro_offset_q  <= cfg_wdata_i[7:0];
        CFG_GYRO_GAIN:    gyro_gain_q    <= cfg_wdata_i;
        CFG_RATE_COEFF:   rate_coeff_q   <= cfg_wdata_i;
        CFG_FUSION_COEFF: fusion_coeff_q <= cfg_wdata_i;
        CFG_FUSED_MIN:    fused_min_q    <= cfg_wdata_i[9:0];
        CFG_FUSED_MAX:    fused_max_q    <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // sequencer: step counter, control word, stalls
  step_e  step_q, step_d;
  ucode_t uw;
  logic   in_txn, stall, out_load;
  ctrl_t  ctrl;

  always_comb begin
    uw       = tcf_ucode(step_q);
    in_txn   = s_axis_tvalid && uw.wait_in;
    stall    = (uw.wait_in && !s_axis_tvalid) ||
               (uw.wait_out && m_axis_tvalid && !m_axis_tready);
    out_load = uw.wait_out && !stall;
    step_d   = stall ? step_q : uw.next;

    ctrl         = uw.ctrl;
    ctrl.load_in = uw.ctrl.load_in && in_txn;
    ctrl.mul_en  = uw.ctrl.mul_en && !stall;
    ctrl.rate_en = uw.ctrl.rate_en && !stall;
    ctrl.sub_en  = uw.ctrl.sub_en && !stall;
    ctrl.fuse_en = uw.ctrl.fuse_en && !stall;
  end

  assign s_axis_tready = uw.wait_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IN;
    end else begin
      step_q <= step_d;
    end
  end

  // datapath
  res_t res;

  tcf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .accel_sample_i (s_axis_tdata[15:0]),
    .gyro_sample_i  (s_axis_tdata[31:16]),
    .gyro_offset_i  (gyro_offset_q),
    .gyro_gain_i    (gyro_gain_q),
    .rate_coeff_i   (rate_coeff_q),
    .fusion_coeff_i (fusion_coeff_q),
    .fused_min_i    (fused_min_q),
    .fused_max_i    (fused_max_q),
    .res_o          (res)
  );

  // output register
  logic out_valid_q, out_valid_d;
  res_t out_q;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

>>> sim/tcf_tilt_checker.sv
// tcf_tilt_checker: watches the sample, result and register ports of the tilt filter,
// predicts each result in fixed point and compares it field by field
// depends on tcf_pkg
`timescale 1ns / 100ps

module tcf_tilt_checker
  import tcf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // sample channel
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire logic [31:0]           in_data_i,    // accel_sample[15:0], gyro_sample[31:16]
  // result channel
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire logic [31:0]           out_data_i,   // unfused_angle[11:0],
                                                   // fused_angle_out[21:12], rate_out[31:22]
  // register writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // status toward the test
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int     GAIN_FRAC   = 14;
  localparam int     COEFF_FRAC  = 16;
  localparam longint ANGLE_BIAS  = 4000;
  localparam longint RATE_BIAS   = 1000;
  localparam longint SCALE_TOP   = 999;
  localparam longint RATE_MAX    = 32767;
  localparam longint RATE_MIN    = -32768;
  localparam int     MAX_REPORTS = 40;

  // shadow copy of the registers and of the fused angle
  logic [7:0]         gyro_offset_q;
  logic [15:0]        gyro_gain_q;
  logic [15:0]        rate_coeff_q;
  logic [15:0]        fusion_coeff_q;
  logic [9:0]         fused_min_q;
  logic [9:0]         fused_max_q;
  logic [FUSED_W-1:0] fused_state_q;

  res_t expected_tilt_q[$];
  int   fails;
  int   pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // division by a power of two, rounded toward zero
  function automatic longint trunc_shift(input longint v, input int s);
    if (v < 0) return -((-v) >>> s);
    return v >>> s;
  endfunction

  // one filter step on the shadow state
  task automatic predict_tilt(input logic [15:0] accel, input logic [15:0] gyro,
                              output res_t r);
    longint one, ang, g, rate, x, err, lo, hi, ip, ro;
    one  = longint'(1) << FRAC_BITS;
    ang  = ((longint'($signed(accel)) >>> 2) + ANGLE_BIAS) >>> 3;
    g    = longint'($signed(gyro)) >>> 2;
    rate = trunc_shift((-g - longint'(gyro_offset_q)) * longint'(gyro_gain_q), GAIN_FRAC);
    if (rate > RATE_MAX) rate = RATE_MAX;
    if (rate < RATE_MIN) rate = RATE_MIN;

    // integrate the rate, then pull toward the accelerometer angle
    x   = longint'(fused_state_q);
    x  -= trunc_shift(rate * longint'(rate_coeff_q) * one, COEFF_FRAC);
    err = ang * one - x;
    x  += trunc_shift(err * longint'(fusion_coeff_q), COEFF_FRAC);

    // when the bounds cross, values below the lower bound take it, all others the upper
    lo = longint'(fused_min_q) * one;
    hi = longint'(fused_max_q) * one;
    if (x < lo) x = lo;
    else if (x > hi) x = hi;
    fused_state_q = x[FUSED_W-1:0];

    ip = x >>> FRAC_BITS;
    r.fused_angle_out = (ip > SCALE_TOP) ? 10'd0 : 10'(SCALE_TOP - ip);
    ro = (rate + RATE_BIAS) >>> 1;
    if (ro < 0) ro = 0;
    else if (ro > SCALE_TOP) ro = SCALE_TOP;
    r.rate_out      = 10'(ro);
    r.unfused_angle = 12'(ang);
  endtask

  task automatic report_field(input string field, input int want_v, input int got_v);
    fails++;
    if (fails <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
  endtask

  // watch all three ports at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      gyro_offset_q  = RST_GYRO_OFFSET;
      gyro_gain_q    = RST_GYRO_GAIN;
      rate_coeff_q   = RST_RATE_COEFF;
      fusion_coeff_q = RST_FUSION_COEFF;
      fused_min_q    = RST_FUSED_MIN;
      fused_max_q    = RST_FUSED_MAX;
      fused_state_q  = {RST_FUSED_INT, {FRAC_BITS{1'b0}}};
      expected_tilt_q.delete();
      fails   = 0;
      pending = 0;
    end else begin
      // result transaction against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got = res_t'(out_data_i);
        if (expected_tilt_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: result with none expected, expected none, actual %h",
                     $time, out_data_i);
        end else begin
          want = expected_tilt_q.pop_front();
          if (got.unfused_angle !== want.unfused_angle)
            report_field("unfused_angle", int'(want.unfused_angle), int'(got.unfused_angle));
          if (got.fused_angle_out !== want.fused_angle_out)
            report_field("fused_angle_out", int'(want.fused_angle_out),
                         int'(got.fused_angle_out));
          if (got.rate_out !== want.rate_out)
            report_field("rate_out", int'(want.rate_out), int'(got.rate_out));
        end
      end

      // register write, unused indexes dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GYRO_OFFSET:  gyro_offset_q  = cfg_wdata_i[7:0];
          CFG_GYRO_GAIN:    gyro_gain_q    = cfg_wdata_i;
          CFG_RATE_COEFF:   rate_coeff_q   = cfg_wdata_i;
          CFG_FUSION_COEFF: fusion_coeff_q = cfg_wdata_i;
          CFG_FUSED_MIN:    fused_min_q    = cfg_wdata_i[9:0];
          CFG_FUSED_MAX:    fused_max_q    = cfg_wdata_i[9:0];
          default: begin
          end
        endcase
      end

      // sample transaction
      if (in_valid_i && in_ready_i) begin
        predict_tilt(in_data_i[15:0], in_data_i[31:16], want);
        expected_tilt_q.push_back(want);
      end
      pending = expected_tilt_q.size();
    end
  end

endmodule

>>> sim/tb_top.sv
// tb_top: stimulus and verdict for tilt_complementary_filter; drives samples in bursts,
// stalls results and rewrites the registers between phases
// depends on tcf_pkg, tilt_complementary_filter and tcf_tilt_checker
`timescale 1ns / 100ps

module tb_top;
  import tcf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 113;
  localparam int ACCEL_SPREAD   = 8000;
  localparam int GYRO_SPREAD    = 600;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_HOLD
  } rx_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;   // accel_sample[15:0], gyro_sample[31:16]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;   // unfused_angle[11:0],
                                         // fused_angle_out[21:12], rate_out[31:22]
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  always #2 clk = ~clk;

  tilt_complementary_filter dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  tcf_tilt_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // one register write, strobe held for a single cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // offer one sample pair and wait for its transaction
  task automatic send_item(input logic [15:0] accel, input logic [15:0] gyro);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {gyro, accel};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // drop valid with noise on the data lines; n sets the length of the gap
  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // stop offering, wait for every result, then let the last step settle
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // corners, full random or a value near a working point
  function automatic logic [15:0] pick_sample(input logic [15:0] centre, input int spread);
    int unsigned kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) return 16'h8000;
    if (kind == 1) return 16'h7fff;
    if (kind == 2) return 16'h0000;
    if (kind == 3) return 16'hffff;
    if (kind < 12) return 16'($urandom);
    return centre + 16'($urandom_range(0, 2 * spread)) - 16'(spread);
  endfunction

  // register setting: zero, top, small or anywhere in range
  function automatic logic [15:0] pick_setting(input logic [15:0] top);
    int unsigned kind;
    kind = $urandom_range(0, 3);
    case (kind)
      0: return 16'd0;
      1: return top;
      2: return 16'($urandom_range(0, int'(top) >> 6));
      default: return 16'($urandom_range(0, int'(top)));
    endcase
  endfunction

  // result side: stretches of open, coin-flip, sparse and long hold-off
  initial begin : receiver
    int       stretch;
    int       len;
    rx_mode_e mode;
    m_axis_tready = 1'b0;
    stretch = 0;
    forever begin
      stretch++;
      if (stretch % 8 == 5) begin
        mode = RX_HOLD;
        len  = $urandom_range(60, 120);
      end else begin
        mode = rx_mode_e'($urandom_range(0, 2));
        len  = $urandom_range(5, 60);
      end
      repeat (len) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= 1'b0;
        endcase
      end
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [7:0]  offset;
    logic [15:0] gyro_rest;
    int          sent;
    int          burst;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_GYRO_OFFSET;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: field corners and a resting pair
    send_item(16'h8000, 16'h8000);
    send_item(16'h7fff, 16'h7fff);
    send_item(16'h0000, 16'h0000);
    send_item(16'hffff, 16'hffff);
    send_item(16'h8000, 16'h7fff);
    send_item(16'h7fff, 16'h8000);
    send_item(16'h0c80, 16'hff98);
    send_item(16'h5555, 16'haaaa);

    // top settings: rate saturates low, angle clamps above the scale
    settle();
    write_reg(CFG_GYRO_OFFSET, 16'hffff);
    write_reg(CFG_GYRO_GAIN, 16'hffff);
    write_reg(CFG_RATE_COEFF, 16'hffff);
    write_reg(CFG_FUSION_COEFF, 16'hffff);
    write_reg(CFG_FUSED_MIN, 16'd0);
    write_reg(CFG_FUSED_MAX, 16'd1023);
    send_item(16'h7fff, 16'h7fff);
    send_item(16'h8000, 16'h8000);
    send_item(16'h0000, 16'h0000);
    send_item(16'h7fff, 16'h0000);

    // zero settings, crossed bounds, writes to unused indexes
    settle();
    write_reg(CFG_GYRO_OFFSET, 16'd0);
    write_reg(CFG_GYRO_GAIN, 16'd0);
    write_reg(CFG_RATE_COEFF, 16'd0);
    write_reg(CFG_FUSION_COEFF, 16'd0);
    write_reg(CFG_FUSED_MIN, 16'd900);
    write_reg(CFG_FUSED_MAX, 16'd100);
    write_reg(CFG_SPARE_LO, 16'hffff);
    write_reg(CFG_SPARE_HI, 16'h1234);
    send_item(16'h1234, 16'h8000);
    send_item(16'hedcb, 16'h7fff);
    send_item(16'h0000, 16'hffff);

    // both bounds above the scale: fused output saturates to zero
    settle();
    write_reg(CFG_GYRO_GAIN, 16'd32408);
    write_reg(CFG_RATE_COEFF, 16'd328);
    write_reg(CFG_FUSION_COEFF, 16'hffff);
    write_reg(CFG_FUSED_MIN, 16'd1010);
    write_reg(CFG_FUSED_MAX, 16'd1000);
    send_item(16'h7fff, 16'h0000);
    send_item(16'h8000, 16'h7fff);
    send_item(16'h0000, 16'h8000);

    // random phases, new settings each time
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      offset = 8'(pick_setting(16'd255));
      write_reg(CFG_GYRO_OFFSET, {8'($urandom), offset});
      write_reg(CFG_GYRO_GAIN, pick_setting(16'hffff));
      write_reg(CFG_RATE_COEFF, pick_setting(16'hffff));
      write_reg(CFG_FUSION_COEFF, pick_setting(16'hffff));
      if (ph % 3 != 0) begin
        write_reg(CFG_FUSED_MIN, {6'($urandom), 10'($urandom_range(0, 400))});
        write_reg(CFG_FUSED_MAX, {6'($urandom), 10'($urandom_range(500, 999))});
      end else begin
        write_reg(CFG_FUSED_MIN, {6'($urandom), 10'(pick_setting(16'd1023))});
        write_reg(CFG_FUSED_MAX, {6'($urandom), 10'(pick_setting(16'd1023))});
      end
      if ($urandom_range(0, 1) == 1)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));

      // gyro word that gives zero rate under this offset
      gyro_rest = 16'(-4 * int'(offset));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          send_item(pick_sample(16'h0000, ACCEL_SPREAD), pick_sample(gyro_rest, GYRO_SPREAD));
          sent++;
        end
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
